// ----- rtl/core/hp_pkg.sv -----
// ----------------------------------------------------------------------------
// hp_pkg: shared types and constants for the histogram percentile block
// Holds the controller state type and the fixed constants of the percent rule.
// ----------------------------------------------------------------------------
package hp_pkg;

    // Width of the percent register.
    localparam int PCT_W = 7;

    // Percent after reset, the fallback for out-of-range percents, and the
    // first percent that is out of range.
    localparam logic [PCT_W-1:0] PCT_DEFAULT  = 7'd50;
    localparam logic [PCT_W-1:0] PCT_FALLBACK = 7'd50;
    localparam logic [PCT_W-1:0] PCT_LIMIT    = 7'd100;

    // Divisor of the skip count (percent scale).
    localparam int SKIP_DIV = 100;

    typedef enum logic [1:0] {
        ST_ACC,   // collecting pixels of a frame
        ST_MULT,  // forming total * percent, starting the read of bin 0
        ST_SCAN   // walking the bins, one per cycle
    } t_state;

endpackage

// ----- rtl/core/histogram_percentile.sv -----
// ----------------------------------------------------------------------------
// histogram_percentile: percentile bin search over a frame of pixels
// Builds a histogram of one frame in a synchronous memory, then walks the
// bins until the sum reaches the requested fraction of the pixel count.
// ----------------------------------------------------------------------------
//
//  Channel     Direction  Signals                                  Role
//  ---------   ---------  ---------------------------------------  --------------
//  s_axis      in         tvalid, tready, tdata, tlast             pixel items
//  m_axis      out        tvalid, tready, tdata                    bin count item
//  cfg         in         i_cfg_wr_en, i_cfg_wr_data               percent reg
//
//  While a frame streams in, one pixel item is taken every cycle; the bin
//  update is a read-modify-write through the histogram memory with a
//  registered read port, and a forwarding register covers back-to-back
//  pixels of the same value as well as the last pixel of a frame landing in
//  the first bin that the walk reads.
//  After the item with tlast, tready stays low through ST_MULT and the walk
//  over B bins (at most the largest pixel value plus one), because the
//  walk reads one bin per cycle from the single read port; a result still
//  waiting from the previous frame holds the walk's end until it is taken.
//  Reset (synchronous, active low) clears the controller, the counters and
//  the per-bin valid bits; the memory contents themselves are never cleared,
//  a bin whose valid bit is low reads as zero. All valid bits drop together
//  when the walk of each frame ends.
//  The result waits in an output register; a stalled m_axis only holds the
//  end of the walk, and the next frame may stream in while a result waits.
//
module histogram_percentile #(
    parameter int PIXEL_BITS = 8,
    parameter int COUNT_BITS = 21
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    // Pixel stream.
    input  logic                                     s_axis_tvalid,
    output logic                                     s_axis_tready,
    // tdata fields from bit 0 up: pixel [PIXEL_BITS-1:0], zero padding.
    input  logic [((PIXEL_BITS+7)/8)*8-1:0]          s_axis_tdata,
    input  logic                                     s_axis_tlast,
    // Result stream.
    output logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready,
    // tdata fields from bit 0 up: quantile_value [PIXEL_BITS:0], zero padding.
    output logic [((PIXEL_BITS+8)/8)*8-1:0]          m_axis_tdata,
    // Percent register write.
    input  logic                                     i_cfg_wr_en,
    input  logic [hp_pkg::PCT_W-1:0]                 i_cfg_wr_data
);
    import hp_pkg::*;

    localparam int NUM_BINS = 1 << PIXEL_BITS;
    localparam int IDX_W    = PIXEL_BITS + 1;
    localparam int OUT_W    = ((PIXEL_BITS + 8) / 8) * 8;
    localparam int SUM_W    = COUNT_BITS + 1;
    localparam int PROD_W   = COUNT_BITS + PCT_W;
    localparam int CMP_W    = SUM_W + 7;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [CMP_W-1:0]      DIV_C     = CMP_W'(SKIP_DIV);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state r_state, n_state;

    logic [PCT_W-1:0]      r_percent;

    // Histogram memory and one valid bit per bin.
    logic [COUNT_BITS-1:0] r_mem [NUM_BINS];
    logic [NUM_BINS-1:0]   r_valid;
    logic [COUNT_BITS-1:0] r_rd_data;
    logic                  r_rd_ok;

    // Update stage: pixel whose bin read is in flight.
    logic                  r_s1_vld;
    logic [PIXEL_BITS-1:0] r_s1_px;
    // Last write, forwarded to a read issued in the same cycle.
    logic                  r_fw_vld;
    logic [PIXEL_BITS-1:0] r_fw_px;
    logic [COUNT_BITS-1:0] r_fw_cnt;

    // Frame statistics.
    logic [COUNT_BITS-1:0] r_total;
    logic [PIXEL_BITS-1:0] r_max;

    // Walk state.
    logic [PROD_W-1:0]     r_prod;
    logic [SUM_W-1:0]      r_sum;
    logic [IDX_W-1:0]      r_idx;

    // Result slot.
    logic                  r_out_vld;
    logic [IDX_W-1:0]      r_out_val;

    // ------------------------------------------------------------------
    // Combinational signals
    // ------------------------------------------------------------------
    logic                  in_acc;
    logic [PIXEL_BITS-1:0] in_px;
    logic [PIXEL_BITS-1:0] rd_addr;
    logic                  start_walk;
    logic                  scan_step;
    logic                  scan_done;
    logic                  walk_more;
    logic                  out_free;
    logic [COUNT_BITS-1:0] bin_rd;
    logic [COUNT_BITS-1:0] scan_bin;
    logic [COUNT_BITS-1:0] s1_cur;
    logic [COUNT_BITS-1:0] s1_new;
    logic [PCT_W-1:0]      pct_eff;
    logic [CMP_W-1:0]      cmp_lhs;

    assign in_px  = s_axis_tdata[PIXEL_BITS-1:0];
    assign in_acc = s_axis_tvalid && s_axis_tready;

    // A bin whose valid bit is low belongs to no pixel of this frame.
    assign bin_rd = r_rd_ok ? r_rd_data : '0;

    // The bin being updated may have been written in the very cycle its
    // read was issued; the forwarding register holds that newer count.
    assign s1_cur = (r_fw_vld && (r_fw_px == r_s1_px)) ? r_fw_cnt : bin_rd;
    assign s1_new = (s1_cur == COUNT_MAX) ? s1_cur : s1_cur + 1'b1;

    // The read of bin 0 at the start of the walk coincides with the write of
    // the frame's last pixel, so the walk takes the forwarded count as well.
    assign scan_bin = (r_fw_vld && (r_fw_px == r_idx[PIXEL_BITS-1:0])) ? r_fw_cnt : bin_rd;

    assign pct_eff = (r_percent >= PCT_LIMIT) ? PCT_FALLBACK : r_percent;

    // sum < floor(total * p / 100) holds exactly when
    // 100 * (sum + 1) <= total * p, so the walk needs no divider.
    assign cmp_lhs   = (CMP_W'(r_sum) + CMP_W'(1)) * DIV_C;
    assign walk_more = (cmp_lhs <= CMP_W'(r_prod)) && (r_idx <= {1'b0, r_max});
    assign out_free  = !r_out_vld || m_axis_tready;

    // ------------------------------------------------------------------
    // Controller: next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_ACC: begin
                if (in_acc && s_axis_tlast) begin
                    n_state = ST_MULT;
                end
            end
            ST_MULT: begin
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (!walk_more && out_free) begin
                    n_state = ST_ACC;
                end
            end
            default: begin
                n_state = ST_ACC;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Controller: outputs
    // ------------------------------------------------------------------
    always_comb begin
        s_axis_tready = 1'b0;
        rd_addr       = in_px;
        start_walk    = 1'b0;
        scan_step     = 1'b0;
        scan_done     = 1'b0;
        unique case (r_state)
            ST_ACC: begin
                s_axis_tready = 1'b1;
                rd_addr       = in_px;
            end
            ST_MULT: begin
                start_walk = 1'b1;
                rd_addr    = '0;
            end
            ST_SCAN: begin
                scan_step = walk_more;
                scan_done = !walk_more && out_free;
                // Past the top bin the address wraps, but the walk stops there.
                rd_addr   = r_idx[PIXEL_BITS-1:0] + 1'b1;
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Histogram memory: one write port, one registered read port
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[rd_addr];
        if (r_s1_vld) begin
            r_mem[r_s1_px] <= s1_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            r_rd_ok <= r_valid[rd_addr];
            if (scan_done) begin
                r_valid <= '0;
            end else if (r_s1_vld) begin
                r_valid[r_s1_px] <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Update pipeline, statistics, walk and result
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_ACC;
            r_percent <= PCT_DEFAULT;
            r_s1_vld  <= 1'b0;
            r_fw_vld  <= 1'b0;
            r_total   <= '0;
            r_max     <= '0;
            r_sum     <= '0;
            r_idx     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_wr_en) begin
                r_percent <= i_cfg_wr_data;
            end

            r_s1_vld <= in_acc;
            r_fw_vld <= r_s1_vld;

            if (in_acc) begin
                if (r_total != COUNT_MAX) begin
                    r_total <= r_total + 1'b1;
                end
                if (in_px > r_max) begin
                    r_max <= in_px;
                end
            end

            if (start_walk) begin
                r_sum <= '0;
                r_idx <= '0;
            end else if (scan_step) begin
                r_sum <= r_sum + SUM_W'(scan_bin);
                r_idx <= r_idx + 1'b1;
            end

            if (scan_done) begin
                r_out_vld <= 1'b1;
                r_total   <= '0;
                r_max     <= '0;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_px <= in_px;
        end
        if (r_s1_vld) begin
            r_fw_px  <= r_s1_px;
            r_fw_cnt <= s1_new;
        end
        if (start_walk) begin
            r_prod <= PROD_W'(r_total) * PROD_W'(pct_eff);
        end
        if (scan_done) begin
            r_out_val <= r_idx;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = OUT_W'(r_out_val);

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // No bin update may still be in flight while the walk reads the memory.
    a_no_update_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> !r_s1_vld)
        else $error("bin update pending during the walk");

    // The frame's closing item stops intake until the walk has finished.
    a_pause_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && s_axis_tlast) |=> !s_axis_tready)
        else $error("input taken right after the last item of a frame");

    // The walk never passes the bin just above the largest pixel value.
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_idx <= IDX_W'({1'b0, r_max}) + 1'b1))
        else $error("walk ran past the largest pixel value");

    // A result appears only at the end of a walk.
    a_result_from_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> ($past(r_state) == ST_SCAN))
        else $error("result raised outside the walk");

endmodule

// ----- test/hp_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hp_checker: scoreboard for the histogram percentile block
// Watches the pixel, result and percent channels, keeps its own histogram of
// the current frame and compares each result item with the predicted count.
// ----------------------------------------------------------------------------
module hp_checker #(
    parameter int PIXEL_BITS = 8,
    parameter int COUNT_BITS = 21
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    input  logic                               i_s_tready,
    input  logic [((PIXEL_BITS+7)/8)*8-1:0]    i_s_tdata,
    input  logic                               i_s_tlast,
    input  logic                               i_m_tvalid,
    input  logic                               i_m_tready,
    input  logic [((PIXEL_BITS+8)/8)*8-1:0]    i_m_tdata,
    input  logic                               i_cfg_wr_en,
    input  logic [hp_pkg::PCT_W-1:0]           i_cfg_wr_data,
    output int                                 o_error_count,
    output int                                 o_pending,
    output int                                 o_results_checked
);
    import hp_pkg::*;

    localparam int NBINS = 1 << PIXEL_BITS;
    localparam int RES_W = ((PIXEL_BITS+8)/8)*8;
    localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_BITS) - 1;

    // Frame state of the predictor.
    logic [COUNT_BITS-1:0] bin_count [NBINS];
    logic [COUNT_BITS-1:0] frame_pixels;
    logic [PIXEL_BITS-1:0] frame_peak;
    logic [PCT_W-1:0]      percent_now;
    logic [PIXEL_BITS:0]   quantile_q [$];

    int errors;
    int checked;

    assign o_error_count     = errors;
    assign o_pending         = quantile_q.size();
    assign o_results_checked = checked;

    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        $display("%0t mismatch: %s got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    // Walk the bins from zero until the running sum reaches the skip count or
    // the largest pixel of the frame has been passed.
    function automatic logic [PIXEL_BITS:0] bins_walked();
        longint unsigned pct;
        longint unsigned skip;
        longint unsigned sum;
        int              idx;
        pct  = 64'((percent_now >= PCT_LIMIT) ? PCT_FALLBACK : percent_now);
        skip = (64'(frame_pixels) * pct) / 64'(SKIP_DIV);
        sum  = 0;
        idx  = 0;
        while (sum < skip && idx <= int'(frame_peak) && idx < NBINS) begin
            sum += 64'(bin_count[idx]);
            idx++;
        end
        return idx[PIXEL_BITS:0];
    endfunction

    task automatic clear_frame();
        foreach (bin_count[i]) bin_count[i] = '0;
        frame_pixels = '0;
        frame_peak   = '0;
    endtask

    initial begin
        errors  = 0;
        checked = 0;
        percent_now = PCT_DEFAULT;
        clear_frame();
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            percent_now = PCT_DEFAULT;
            clear_frame();
            quantile_q.delete();
        end else begin
            if (i_cfg_wr_en)
                percent_now = i_cfg_wr_data;

            if (i_s_tvalid && i_s_tready) begin
                logic [PIXEL_BITS-1:0] px;
                px = i_s_tdata[PIXEL_BITS-1:0];
                if (bin_count[px] < COUNT_MAX) bin_count[px]++;
                if (frame_pixels < COUNT_MAX) frame_pixels++;
                if (px > frame_peak) frame_peak = px;
                if (i_s_tlast) begin
                    quantile_q.push_back(bins_walked());
                    clear_frame();
                end
            end

            if (i_m_tvalid && i_m_tready) begin
                if (quantile_q.size() == 0) begin
                    report_mismatch("result with nothing expected, value",
                                    longint'(i_m_tdata), -1);
                end else begin
                    logic [RES_W-1:0] want;
                    want = RES_W'(quantile_q.pop_front());
                    if (i_m_tdata !== want)
                        report_mismatch("quantile_value", longint'(i_m_tdata),
                                        longint'(want));
                    checked++;
                end
            end
        end
    end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for histogram_percentile
// Streams directed and random pixel frames under several percent settings,
// with random gaps on the pixel side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_top;
    import hp_pkg::*;

    localparam int PIXEL_BITS = 8;
    localparam int COUNT_BITS = 21;
    localparam int S_W        = ((PIXEL_BITS+7)/8)*8;
    localparam int M_W        = ((PIXEL_BITS+8)/8)*8;

    // This pause covers the walk after a last item, over at most 256 bins,
    // and one receiver stall that the result may then sit through.
    localparam int WALK_PAUSE = 300;
    // Far above the slowest correct run.
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 400;
    localparam int MIN_FRAMES   = 40;

    logic             i_clk   = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [S_W-1:0]   s_tdata  = '0;
    logic             s_tlast  = 1'b0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [M_W-1:0]   m_tdata;
    logic             cfg_wr_en   = 1'b0;
    logic [PCT_W-1:0] cfg_wr_data = '0;

    int error_count;
    int pending;
    int results_checked;

    // Idle behavior of both sides; switched per frame so that long bursts
    // without gaps alternate with heavily throttled stretches.
    bit tx_gaps_on  = 1'b1;
    bit rx_stall_on = 1'b1;
    int rx_wait = 0;
    int rx_next;

    int pixels_sent = 0;
    int frames_sent = 0;
    int cycle_count = 0;
    logic [PIXEL_BITS-1:0] frame_px [$];

    histogram_percentile #(
        .PIXEL_BITS(PIXEL_BITS),
        .COUNT_BITS(COUNT_BITS)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_tvalid),
        .s_axis_tready(s_tready),
        .s_axis_tdata (s_tdata),   // bit 0 up: pixel [7:0]
        .s_axis_tlast (s_tlast),
        .m_axis_tvalid(m_tvalid),
        .m_axis_tready(m_tready),
        .m_axis_tdata (m_tdata),   // bit 0 up: quantile_value [8:0], zero padding
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data)
    );

    hp_checker #(
        .PIXEL_BITS(PIXEL_BITS),
        .COUNT_BITS(COUNT_BITS)
    ) u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_s_tvalid       (s_tvalid),
        .i_s_tready       (s_tready),
        .i_s_tdata        (s_tdata),
        .i_s_tlast        (s_tlast),
        .i_m_tvalid       (m_tvalid),
        .i_m_tready       (m_tready),
        .i_m_tdata        (m_tdata),
        .i_cfg_wr_en      (cfg_wr_en),
        .i_cfg_wr_data    (cfg_wr_data),
        .o_error_count    (error_count),
        .o_pending        (pending),
        .o_results_checked(results_checked)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Result side: after each accepted item, ready drops for a random number
    // of cycles. A draw of zero keeps ready high, so back-to-back results are
    // possible.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            rx_wait  <= 0;
        end else if (m_tready && m_tvalid) begin
            rx_next = rx_stall_on ? $urandom_range(0, 17) : 0;
            if (rx_next != 0) begin
                m_tready <= 1'b0;
                rx_wait  <= rx_next - 1;
            end
        end else if (!m_tready) begin
            if (rx_wait == 0)
                m_tready <= 1'b1;
            else
                rx_wait <= rx_wait - 1;
        end
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results still expected",
                 cycle_count, pending);
        $display("tb: failure");
        $finish;
    end

    // Offers one pixel item after an optional gap and returns at the edge
    // where it is accepted. Valid is only touched once per edge: either it is
    // dropped for a gap or it is driven high with the next item.
    task automatic push_pixel(input logic [PIXEL_BITS-1:0] px, input logic is_last);
        int gap;
        gap = tx_gaps_on ? $urandom_range(0, 17) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_W'(px);
        s_tlast  <= is_last;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        pixels_sent++;
    endtask

    // Sends frame_px as one frame; the final pixel carries the last flag.
    task automatic send_frame();
        foreach (frame_px[i])
            push_pixel(frame_px[i], i == frame_px.size() - 1);
        frames_sent++;
    endtask

    // Lets the block go idle: all expected results in, then the walk pause.
    // The first wait moves past the edge of the final acceptance so that the
    // checker has already queued the last expectation.
    task automatic drain_block();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (WALK_PAUSE) @(posedge i_clk);
    endtask

    task automatic write_percent(input logic [PCT_W-1:0] pct);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= pct;
        @(posedge i_clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Random frame: mostly short, a few long, with one of several pixel
    // distributions so that skip counts land both early and late in the bins.
    task automatic build_random_frame();
        int len;
        int style;
        int sel;
        logic [PIXEL_BITS-1:0] base;
        sel = $urandom_range(0, 99);
        if (sel < 80)
            len = $urandom_range(1, 12);
        else if (sel < 95)
            len = $urandom_range(13, 40);
        else
            len = $urandom_range(41, 80);
        style = $urandom_range(0, 4);
        base  = PIXEL_BITS'($urandom_range(0, 255));
        frame_px.delete();
        for (int i = 0; i < len; i++) begin
            case (style)
                0: frame_px.push_back(PIXEL_BITS'($urandom_range(0, 255)));
                1: frame_px.push_back(PIXEL_BITS'(base + $urandom_range(0, 7)));
                // Mostly black frames.
                2: frame_px.push_back(($urandom_range(0, 3) == 0) ?
                                      PIXEL_BITS'($urandom_range(0, 255)) : 8'd0);
                // Few dark pixels and a bright tail at full scale.
                3: frame_px.push_back(($urandom_range(0, 2) == 0) ?
                                      PIXEL_BITS'($urandom_range(0, 3)) : 8'd255);
                default: frame_px.push_back({2'($urandom_range(0, 3)), 6'b0});
            endcase
        end
    endtask

    initial begin
        logic [PCT_W-1:0] phase_pct [8];
        int phase;
        int phase_items;
        phase_pct = '{7'd1, 7'd99, 7'd0, 7'd127, 7'd64, 7'd42, 7'd100, 7'd17};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed frames at the reset percent of 50. A single pixel gives a
        // skip of zero, an all-black frame stops after bin 0, and a mixed frame
        // stops after bin 85.
        frame_px = '{8'd0};
        send_frame();
        frame_px = '{8'd0, 8'd0, 8'd0, 8'd0};
        send_frame();
        frame_px = '{8'd255, 8'd85, 8'd170, 8'd1};
        send_frame();
        drain_block();

        // At 99 percent the sum only reaches the skip count in the top bin, so
        // all 256 bins are walked and the top result bit is set.
        write_percent(7'd99);
        frame_px = '{8'd0, 8'd255, 8'd255};
        send_frame();
        drain_block();

        // The largest register value falls back to the median.
        write_percent(7'd127);
        frame_px = '{8'd200, 8'd10, 8'd10, 8'd10};
        send_frame();
        drain_block();

        // Zero percent means a zero skip count: nothing is walked.
        write_percent(7'd0);
        frame_px = '{8'd7, 8'd3};
        send_frame();
        drain_block();

        // Exactly 100 also falls back to the median.
        write_percent(PCT_LIMIT);
        frame_px = '{8'd255, 8'd255};
        send_frame();
        drain_block();

        // Random frames, in phases that each run under their own percent.
        phase_items = pixels_sent;
        phase = 0;
        while (pixels_sent < phase_items + RANDOM_ITEMS || frames_sent < MIN_FRAMES) begin
            int start;
            write_percent(phase < 8 ? phase_pct[phase] : PCT_W'($urandom_range(0, 127)));
            start = pixels_sent;
            while (pixels_sent - start < 50) begin
                tx_gaps_on  = ($urandom_range(0, 3) != 0);
                rx_stall_on = ($urandom_range(0, 3) != 0);
                build_random_frame();
                send_frame();
            end
            drain_block();
            phase++;
        end

        $display("summary: %0d pixel items in %0d frames under %0d percent settings",
                 pixels_sent, frames_sent, phase + 5);
        $display("summary: %0d results compared, %0d mismatches",
                 results_checked, error_count);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
